>>> design/bgpd_pkg.sv
// ----------------------------------------------------------------------------
// BGP deframer package
// Shared constants, codes and the result record of the message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package bgpd_pkg;

   localparam int MaxLenLimit = 4096;
   localparam int HardMaxLen  = 4096;
   localparam int MinMsgLen   = 19;
   localparam int MarkerBytes = 16;
   localparam logic [7:0] MarkerValue = 8'hFF;

   localparam int LenWidth   = 13;
   localparam int IndexWidth = 12;

   localparam logic [LenWidth-1:0] LenCap =
      LenWidth'((MaxLenLimit < HardMaxLen) ? MaxLenLimit : HardMaxLen);
   localparam logic [LenWidth-1:0] MaxLenReset = LenWidth'(HardMaxLen);

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef enum logic [1:0] {
      STATUS_DATA       = 2'd0,
      STATUS_BAD_MARKER = 2'd1,
      STATUS_BAD_LENGTH = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]            out_byte;
      logic [IndexWidth-1:0] byte_index;
      logic                  is_last;
      status_type            status;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> design/bgpd_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Stream bytes into the deframer, with a flush flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       flush;

   modport source (output valid, output data_byte, output flush, input ready);
   modport sink   (input valid, input data_byte, input flush, output ready);
endinterface

`default_nettype wire

>>> design/bgpd_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Forwarded message bytes and error reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgpd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [7:0]                          out_byte;
   logic [bgpd_pkg::IndexWidth-1:0]     byte_index;
   logic                                is_last;
   bgpd_pkg::status_type                status;

   modport source (output valid, output out_byte, output byte_index, output is_last,
                   output status, input ready);
   modport sink   (input valid, input out_byte, input byte_index, input is_last,
                   input status, output ready);
endinterface

`default_nettype wire

>>> design/bgpd_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Write port for the maximum message length register.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgpd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bgpd_pkg::LenWidth-1:0]     max_message_length;

   modport source (output valid, output max_message_length, input ready);
   modport sink   (input valid, input max_message_length, output ready);
endinterface

`default_nettype wire

>>> design/bgp_message_deframer.sv
// ----------------------------------------------------------------------------
// BGP message deframer
// Cuts a byte stream into BGP messages, checking marker and length.
// ----------------------------------------------------------------------------
// One stream byte is taken per clock. Each byte that is forwarded or reported
// as an error reaches the response channel through a four-entry transaction
// queue and then a registered output stage; the request side stalls only when
// that queue is full. Flush transactions and bytes dropped after an error give
// no response. The length limit register is written through the csr channel,
// which is always ready.
`default_nettype none

module bgp_message_deframer (
   input  wire logic   clock,
   input  wire logic   reset,
   bgpd_req_if.sink    req_bus,
   bgpd_rsp_if.source  rsp_bus,
   bgpd_csr_if.sink    csr_bus
);

   logic                   push;
   bgpd_pkg::rsp_item_type push_item;
   logic                   queue_full;
   logic                   pop;
   logic                   not_empty;
   bgpd_pkg::rsp_item_type head_item;

   bgpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .csr        (csr_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   bgpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_item (head_item)
   );

   bgpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head_item (head_item),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire

>>> design/bgpd_front.sv
// ----------------------------------------------------------------------------
// BGP deframer front end
// Accepts stream bytes, tracks framing state and classifies each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bgpd_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bgpd_req_if.sink                    req,
   bgpd_csr_if.sink                    csr,
   input  wire logic                   queue_full,
   output logic                        push,
   output bgpd_pkg::rsp_item_type      push_item
);

   logic [bgpd_pkg::IndexWidth-1:0] pos_ff, pos_in;
   logic [7:0]                      len_hi_ff, len_hi_in;
   logic [bgpd_pkg::LenWidth-1:0]   msg_len_ff, msg_len_in;
   logic                            stuck_ff, stuck_in;
   logic [bgpd_pkg::LenWidth-1:0]   max_len_ff, max_len_in;

   logic                            accept;
   logic [bgpd_pkg::LenWidth-1:0]   eff_max;
   logic [15:0]                     len_word;
   logic [bgpd_pkg::LenWidth-1:0]   pos_next;

   assign req.ready = !queue_full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   assign max_len_in = (csr.valid && csr.ready) ? csr.max_message_length : max_len_ff;
   assign eff_max    = (max_len_ff > bgpd_pkg::LenCap) ? bgpd_pkg::LenCap : max_len_ff;
   assign len_word   = {len_hi_ff, req.data_byte};
   assign pos_next   = {1'b0, pos_ff} + bgpd_pkg::LenWidth'(1);

   always_comb begin
      pos_in               = pos_ff;
      len_hi_in            = len_hi_ff;
      msg_len_in           = msg_len_ff;
      stuck_in             = stuck_ff;
      push                 = 1'b0;
      push_item.out_byte   = req.data_byte;
      push_item.byte_index = pos_ff;
      push_item.is_last    = 1'b0;
      push_item.status     = bgpd_pkg::STATUS_DATA;
      if (accept) begin
         if (req.flush) begin
            pos_in     = '0;
            len_hi_in  = '0;
            msg_len_in = '0;
            stuck_in   = 1'b0;
         end else if (!stuck_ff) begin
            push = 1'b1;
            if (pos_ff < bgpd_pkg::IndexWidth'(bgpd_pkg::MarkerBytes)) begin
               if (req.data_byte != bgpd_pkg::MarkerValue) begin
                  stuck_in         = 1'b1;
                  push_item.status = bgpd_pkg::STATUS_BAD_MARKER;
               end else begin
                  pos_in = pos_next[bgpd_pkg::IndexWidth-1:0];
               end
            end else if (pos_ff == bgpd_pkg::IndexWidth'(bgpd_pkg::MarkerBytes)) begin
               len_hi_in = req.data_byte;
               pos_in    = pos_next[bgpd_pkg::IndexWidth-1:0];
            end else if (pos_ff == bgpd_pkg::IndexWidth'(bgpd_pkg::MarkerBytes + 1)) begin
               if (len_word < 16'(bgpd_pkg::MinMsgLen) || len_word > {3'b000, eff_max}) begin
                  stuck_in         = 1'b1;
                  push_item.status = bgpd_pkg::STATUS_BAD_LENGTH;
               end else begin
                  msg_len_in = len_word[bgpd_pkg::LenWidth-1:0];
                  pos_in     = pos_next[bgpd_pkg::IndexWidth-1:0];
               end
            end else if (pos_next >= msg_len_ff) begin
               pos_in            = '0;
               push_item.is_last = 1'b1;
            end else begin
               pos_in = pos_next[bgpd_pkg::IndexWidth-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         len_hi_ff  <= '0;
         msg_len_ff <= '0;
         stuck_ff   <= 1'b0;
         max_len_ff <= bgpd_pkg::MaxLenReset;
      end else begin
         pos_ff     <= pos_in;
         len_hi_ff  <= len_hi_in;
         msg_len_ff <= msg_len_in;
         stuck_ff   <= stuck_in;
         max_len_ff <= max_len_in;
      end
   end

   // errors latch until flush
   assert property (@(posedge clock) disable iff (reset)
      push && push_item.status != bgpd_pkg::STATUS_DATA |=> stuck_ff)
      else $error("error result without stuck state");

   assert property (@(posedge clock) disable iff (reset)
      stuck_ff && !(accept && req.flush) |=> stuck_ff)
      else $error("stuck state left without flush");

   assert property (@(posedge clock) disable iff (reset)
      stuck_ff |-> !push)
      else $error("result pushed while stuck");

endmodule

`default_nettype wire

>>> design/bgpd_queue.sv
// ----------------------------------------------------------------------------
// BGP deframer queue
// Short FIFO of classified results between front end and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bgpd_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire bgpd_pkg::rsp_item_type push_item,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        not_empty,
   output bgpd_pkg::rsp_item_type      head_item
);

   bgpd_pkg::rsp_item_type         mem [bgpd_pkg::QueueDepth];
   logic [bgpd_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bgpd_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bgpd_pkg::QueueCntW-1:0] count_ff, count_in;

   assign full      = (count_ff == bgpd_pkg::QueueCntW'(bgpd_pkg::QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head_item = mem[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= bgpd_pkg::QueueCntW'(bgpd_pkg::QueueDepth))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> design/bgpd_back.sv
// ----------------------------------------------------------------------------
// BGP deframer output stage
// Drains the queue into the registered response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bgpd_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   not_empty,
   input  wire bgpd_pkg::rsp_item_type head_item,
   output logic                        pop,
   bgpd_rsp_if.source                  rsp
);

   logic                   valid_ff, valid_in;
   bgpd_pkg::rsp_item_type item_ff, item_in;

   assign pop      = not_empty && (!valid_ff || rsp.ready);
   assign valid_in = pop ? 1'b1 : (valid_ff && !rsp.ready);
   assign item_in  = pop ? head_item : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp.valid      = valid_ff;
   assign rsp.out_byte   = item_ff.out_byte;
   assign rsp.byte_index = item_ff.byte_index;
   assign rsp.is_last    = item_ff.is_last;
   assign rsp.status     = item_ff.status;

endmodule

`default_nettype wire
